// File: hdl/sas_pkg.sv
// Shared types and constants for the slot allocator with free stack.
// No dependencies; every other file in hdl/ refers to this package.
package sas_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int CFG_W    = 9;
  localparam logic [CFG_W-1:0] MAX_SLOTS_RST = CFG_W'(256);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // request transfer this cycle: latch payload
    logic commit;  // update counters/stack and load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register full and not being taken
  } stat_t;

endpackage

// File: hdl/sas_ifs.sv
// Channel interfaces: allocate/free requests, results, configuration write.
// Depends on sas_pkg for field widths.
interface sas_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [sas_pkg::IDX_W-1:0] free_index;
  modport source (output valid, req_type, free_index, input ready);
  modport sink   (input valid, req_type, free_index, output ready);
endinterface

interface sas_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [sas_pkg::IDX_W-1:0] slot_index;
  modport source (output valid, status, slot_index, input ready);
  modport sink   (input valid, status, slot_index, output ready);
endinterface

interface sas_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [sas_pkg::CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/sas_ctrl.sv
// Controller FSM: accepts one request, then commits it once the result
// register can take the answer. Depends on sas_pkg.
module sas_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sas_pkg::stat_t  stat,
  output sas_pkg::cmd_t   cmd
);

  sas_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sas_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sas_pkg::S_IDLE: begin
        if (in_valid) state_next = sas_pkg::S_EXEC;
      end
      sas_pkg::S_EXEC: begin
        if (!stat.out_busy) state_next = sas_pkg::S_IDLE;
      end
      default: state_next = sas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      sas_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      sas_pkg::S_EXEC: begin
        cmd.commit = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/sas_dp.sv
// Datapath: free stack memory, free/high-water counters, limit register,
// result register. Depends on sas_pkg.
module sas_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sas_pkg::cmd_t              cmd,
  output sas_pkg::stat_t             stat,
  input  logic                       in_req_type,
  input  logic [sas_pkg::IDX_W-1:0]  in_free_index,
  input  logic                       cfg_we,
  input  logic [sas_pkg::CFG_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [sas_pkg::IDX_W-1:0]  out_slot_index
);

  logic [sas_pkg::IDX_W-1:0] stack_mem [sas_pkg::CAPACITY];
  logic [sas_pkg::IDX_W-1:0] top_data;

  logic [sas_pkg::CFG_W-1:0] max_slots;
  logic [sas_pkg::CNT_W-1:0] free_count, free_count_next;
  logic [sas_pkg::CNT_W-1:0] next_unused, next_unused_next;
  logic                      req_type;
  logic [sas_pkg::IDX_W-1:0] free_index;

  logic [sas_pkg::CNT_W-1:0] lim;
  logic [sas_pkg::CNT_W-1:0] rd_addr;
  sas_pkg::status_t          res_status;
  logic [sas_pkg::IDX_W-1:0] res_slot;
  logic                      push;

  assign stat.out_busy = out_valid && !out_ready;

  // effective limit: min(max_slots, CAPACITY)
  always_comb begin
    if ({1'b0, max_slots} > (sas_pkg::CFG_W + 1)'(sas_pkg::CAPACITY)) begin
      lim = sas_pkg::CNT_W'(sas_pkg::CAPACITY);
    end else begin
      lim = sas_pkg::CNT_W'(max_slots);
    end
  end

  // top of stack is read while idle; counters are stable until the next commit
  assign rd_addr = free_count - sas_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[free_count[sas_pkg::IDX_W-1:0]] <= free_index;
    end
    if (cmd.take) begin
      top_data <= stack_mem[rd_addr[sas_pkg::IDX_W-1:0]];
    end
  end

  always_comb begin
    res_status       = sas_pkg::ST_OK;
    res_slot         = '0;
    push             = 1'b0;
    free_count_next  = free_count;
    next_unused_next = next_unused;
    if (req_type == sas_pkg::REQ_ALLOC) begin
      if (free_count != '0 && free_count <= sas_pkg::CNT_W'(sas_pkg::CAPACITY)) begin
        free_count_next = free_count - sas_pkg::CNT_W'(1);
        res_slot        = top_data;
      end else if (next_unused < lim) begin
        res_slot         = next_unused[sas_pkg::IDX_W-1:0];
        next_unused_next = next_unused + sas_pkg::CNT_W'(1);
      end else begin
        res_status = sas_pkg::ST_NO_SLOT;
      end
    end else begin
      if ({1'b0, free_index} >= lim || free_count >= lim) begin
        res_status = sas_pkg::ST_BAD;
      end else begin
        push            = cmd.commit;
        free_count_next = free_count + sas_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots   <= sas_pkg::MAX_SLOTS_RST;
      free_count  <= '0;
      next_unused <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) max_slots <= cfg_data;
      if (cmd.commit) begin
        free_count  <= free_count_next;
        next_unused <= next_unused_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_type   <= in_req_type;
      free_index <= in_free_index;
    end
    if (cmd.commit) begin
      out_status     <= res_status;
      out_slot_index <= res_slot;
    end
  end

endmodule

// File: hdl/slot_allocator_free_stack_unit.sv
// Top level of the slot allocator: controller plus datapath.
// Depends on sas_pkg, sas_ifs (channel interfaces), sas_ctrl, sas_dp.
//
//   channel  modport  payload                    role
//   req      sink     req_type, free_index       allocate or free request
//   rsp      source   status, slot_index         one result per request
//   cfg      sink     data (max_slots)           limit register write
//
// Each request has an accept cycle that reads the stack top from the
// registered memory port, then a commit cycle that updates the counters
// and loads the result register. A waiting result stalls the commit only;
// the next request is taken as soon as the commit is done.
// Synchronous reset: counters cleared, limit 256; no memory clearing pass.
module slot_allocator_free_stack_unit (
  input logic       clk,
  input logic       rst,
  sas_req_if.sink   req,
  sas_rsp_if.source rsp,
  sas_cfg_if.sink   cfg
);

  sas_pkg::cmd_t  cmd;
  sas_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sas_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (req.req_type),
    .in_free_index  (req.free_index),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_data       (cfg.data),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_slot_index (rsp.slot_index)
  );

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("result not presented after commit");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous one in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != sas_pkg::ST_OK) |-> rsp.slot_index == '0)
    else $error("nonzero slot index on non-ok result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !cmd.commit)
    else $error("result register overwritten while waiting");

endmodule
